// ===== rtl/tts_pkg.sv =====
package tts_pkg;

    // Table and phase geometry
    localparam int TABLE_SIZE = 1000;
    localparam int FRAC_BITS = 16;
    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int PHASE_W = IDX_W + FRAC_BITS;
    localparam int ACC_W = PHASE_W + 2;
    localparam logic [ACC_W-1:0] WRAP_LIMIT = ACC_W'(TABLE_SIZE) << FRAC_BITS;

    // Field widths
    localparam int STEP_W = 26;
    localparam int GAIN_W = 12;
    localparam int DUTY_W = 12;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W = SAMPLE_W + 1;
    localparam int PROD_W = SUM_W + GAIN_W + 1;
    localparam int CFG_INDEX_W = 1;

    // Output scaling
    localparam int SCALE_SHIFT = 18;
    localparam int DUTY_OFFSET = 1200;
    localparam int DUTY_MIN = 176;
    localparam int DUTY_MAX = 2223;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TONE0_STEP = 1'b0,
        REG_TONE1_STEP = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic              en;
        cfg_reg_t          index;
        logic [STEP_W-1:0] data;
    } cfg_write_t;

    typedef logic signed [SAMPLE_W-1:0] sine_table_t [TABLE_SIZE];

    // Sine table construction, evaluated at elaboration only.
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1847;
    localparam logic [63:0] SINE_SCALE = 64'd32767;
    localparam logic [63:0] TAYLOR_DIV [12] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
        64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
    };

    function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [63:0] sin_q60(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2 = mul_q60(x, x);
        term = x;
        sum = x;
        for (int k = 1; k <= 12; k++)
        begin
            term = mul_q60(term, x2) / TAYLOR_DIV[k-1];
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rom_entry(int i);
        logic [63:0] a;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] num;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] mag;
        a = 64'(i) * 64'd4;
        q = (a / 64'(TABLE_SIZE)) & 64'd3;
        r = a % 64'(TABLE_SIZE);
        if (r == 64'd0)
        begin
            if (q == 64'd1)
                return SAMPLE_W'(32767);
            else if (q == 64'd3)
                return -SAMPLE_W'(32767);
            else
                return '0;
        end
        num = q[0] ? (64'(TABLE_SIZE) - r) : r;
        x = (HALF_PI_Q60 / 64'(TABLE_SIZE)) * num
            + ((HALF_PI_Q60 % 64'(TABLE_SIZE)) * num) / 64'(TABLE_SIZE);
        s = sin_q60(x);
        mag = ((s >> 20) * SINE_SCALE) >> 40;
        return q[1] ? -mag[SAMPLE_W-1:0] : mag[SAMPLE_W-1:0];
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t t;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            t[i] = rom_entry(i);
        end
        return t;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

// ===== rtl/tts_gain_if.sv =====
interface tts_gain_if;
    logic                      valid;
    logic                      ready;
    logic [tts_pkg::GAIN_W-1:0] gain_level;

    modport source (output valid, output gain_level, input ready);
    modport sink (input valid, input gain_level, output ready);
endinterface

// ===== rtl/tts_duty_if.sv =====
interface tts_duty_if;
    logic                      valid;
    logic                      ready;
    logic [tts_pkg::DUTY_W-1:0] duty_compare;

    modport source (output valid, output duty_compare, input ready);
    modport sink (input valid, input duty_compare, output ready);
endinterface

// ===== rtl/tts_cfg_if.sv =====
interface tts_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tts_pkg::CFG_INDEX_W-1:0] index;
    logic [tts_pkg::STEP_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/tts_phase.sv =====
module tts_phase (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tts_pkg::cfg_write_t          cfg_wr,
    input  logic                         advance,
    output logic [tts_pkg::IDX_W-1:0]    idx0,
    output logic [tts_pkg::IDX_W-1:0]    idx1
);

    logic [tts_pkg::PHASE_W-1:0] phase0_reg;
    logic [tts_pkg::PHASE_W-1:0] phase0_next;
    logic [tts_pkg::PHASE_W-1:0] phase1_reg;
    logic [tts_pkg::PHASE_W-1:0] phase1_next;
    logic [tts_pkg::STEP_W-1:0]  step0_reg;
    logic [tts_pkg::STEP_W-1:0]  step0_next;
    logic [tts_pkg::STEP_W-1:0]  step1_reg;
    logic [tts_pkg::STEP_W-1:0]  step1_next;
    logic [tts_pkg::PHASE_W-1:0] adv0;
    logic [tts_pkg::PHASE_W-1:0] adv1;

    // The sum can pass the limit twice only for steps above the nominal range.
    function automatic logic [tts_pkg::PHASE_W-1:0] wrap_add(
        logic [tts_pkg::PHASE_W-1:0] ph,
        logic [tts_pkg::STEP_W-1:0]  st
    );
        logic [tts_pkg::ACC_W-1:0] sum;
        logic [tts_pkg::ACC_W-1:0] less1;
        logic [tts_pkg::ACC_W-1:0] less2;
        sum = tts_pkg::ACC_W'(ph) + tts_pkg::ACC_W'(st);
        less1 = sum - tts_pkg::WRAP_LIMIT;
        less2 = sum - (tts_pkg::WRAP_LIMIT << 1);
        if (sum >= (tts_pkg::WRAP_LIMIT << 1))
            return less2[tts_pkg::PHASE_W-1:0];
        else if (sum >= tts_pkg::WRAP_LIMIT)
            return less1[tts_pkg::PHASE_W-1:0];
        else
            return sum[tts_pkg::PHASE_W-1:0];
    endfunction

    assign adv0 = wrap_add(phase0_reg, step0_reg);
    assign adv1 = wrap_add(phase1_reg, step1_reg);

    // The table address is the integer part of the advanced phase.
    assign idx0 = adv0[tts_pkg::PHASE_W-1:tts_pkg::FRAC_BITS];
    assign idx1 = adv1[tts_pkg::PHASE_W-1:tts_pkg::FRAC_BITS];

    always_comb
    begin
        phase0_next = phase0_reg;
        phase1_next = phase1_reg;
        step0_next = step0_reg;
        step1_next = step1_reg;
        if (advance)
        begin
            phase0_next = adv0;
            phase1_next = adv1;
        end
        if (cfg_wr.en)
        begin
            unique case (cfg_wr.index)
                tts_pkg::REG_TONE0_STEP:
                begin
                    step0_next = cfg_wr.data;
                    if (cfg_wr.data == '0)
                        phase0_next = '0;
                end
                tts_pkg::REG_TONE1_STEP:
                begin
                    step1_next = cfg_wr.data;
                    if (cfg_wr.data == '0)
                        phase1_next = '0;
                end
                default:
                begin
                    step0_next = step0_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase0_reg <= '0;
            phase1_reg <= '0;
            step0_reg <= '0;
            step1_reg <= '0;
        end
        else
        begin
            phase0_reg <= phase0_next;
            phase1_reg <= phase1_next;
            step0_reg <= step0_next;
            step1_reg <= step1_next;
        end
    end

`ifndef ASSERT_OFF
    a_phase0_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        tts_pkg::ACC_W'(phase0_reg) < tts_pkg::WRAP_LIMIT)
        else $error("tone zero phase beyond wrap limit");

    a_phase1_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        tts_pkg::ACC_W'(phase1_reg) < tts_pkg::WRAP_LIMIT)
        else $error("tone one phase beyond wrap limit");

    a_zero_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr.en && (cfg_wr.index == tts_pkg::REG_TONE0_STEP) && (cfg_wr.data == '0)
        |=> (phase0_reg == '0) && (step0_reg == '0))
        else $error("zero step write did not clear tone zero phase");
`endif

endmodule

// ===== rtl/tts_sine_rom.sv =====
module tts_sine_rom (
    input  logic                                clk,
    input  logic                                rd_en,
    input  logic [tts_pkg::IDX_W-1:0]           addr0,
    input  logic [tts_pkg::IDX_W-1:0]           addr1,
    output logic signed [tts_pkg::SAMPLE_W-1:0] data0_reg,
    output logic signed [tts_pkg::SAMPLE_W-1:0] data1_reg
);

    // Two read ports with registered data, loaded while rd_en is high; addresses past the table read entry zero.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (tts_pkg::ACC_W'(addr0) < tts_pkg::ACC_W'(tts_pkg::TABLE_SIZE))
                data0_reg <= tts_pkg::SINE_TABLE[addr0];
            else
                data0_reg <= tts_pkg::SINE_TABLE[0];
            if (tts_pkg::ACC_W'(addr1) < tts_pkg::ACC_W'(tts_pkg::TABLE_SIZE))
                data1_reg <= tts_pkg::SINE_TABLE[addr1];
            else
                data1_reg <= tts_pkg::SINE_TABLE[0];
        end
    end

endmodule

// ===== rtl/tts_mix.sv =====
module tts_mix (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_fire,
    input  logic [tts_pkg::GAIN_W-1:0]          gain_level,
    output logic                                load_en,
    input  logic signed [tts_pkg::SAMPLE_W-1:0] sample0,
    input  logic signed [tts_pkg::SAMPLE_W-1:0] sample1,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tts_pkg::DUTY_W-1:0]          duty_compare
);

    logic                               v1_reg;
    logic                               v1_next;
    logic                               v2_reg;
    logic                               v2_next;
    logic                               v3_reg;
    logic                               v3_next;
    logic                               en2;
    logic                               en3;
    logic [tts_pkg::GAIN_W-1:0]         gain1_reg;
    logic signed [tts_pkg::SUM_W-1:0]   sum1;
    logic signed [tts_pkg::PROD_W-1:0]  prod_next;
    logic signed [tts_pkg::PROD_W-1:0]  prod2_reg;
    logic signed [tts_pkg::PROD_W-1:0]  scaled;
    logic [tts_pkg::DUTY_W-1:0]         duty_next;
    logic [tts_pkg::DUTY_W-1:0]         duty3_reg;

    // A stage loads when it is empty or when the stage after it moves.
    assign en3 = !v3_reg || out_ready;
    assign en2 = !v2_reg || en3;
    assign load_en = !v1_reg || en2;

    assign v1_next = load_en ? in_fire : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign v3_next = en3 ? v2_reg : v3_reg;

    assign sum1 = tts_pkg::SUM_W'(sample0) + tts_pkg::SUM_W'(sample1);
    assign prod_next = tts_pkg::PROD_W'(sum1)
                     * $signed(tts_pkg::PROD_W'(gain1_reg));

    // Arithmetic shift floors negative products; the offset add wraps to the field.
    assign scaled = prod2_reg >>> tts_pkg::SCALE_SHIFT;
    assign duty_next = scaled[tts_pkg::DUTY_W-1:0]
                     + tts_pkg::DUTY_W'(tts_pkg::DUTY_OFFSET);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
            gain1_reg <= gain_level;
        if (en2)
            prod2_reg <= prod_next;
        if (en3)
            duty3_reg <= duty_next;
    end

    assign out_valid = v3_reg;
    assign duty_compare = duty3_reg;

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !load_en |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with an empty stage");

    a_accept_reaches_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && load_en |=> v1_reg)
        else $error("accepted transaction missing from first stage");

    a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (duty3_reg >= tts_pkg::DUTY_W'(tts_pkg::DUTY_MIN))
                && (duty3_reg <= tts_pkg::DUTY_W'(tts_pkg::DUTY_MAX)))
        else $error("compare value outside its range");
`endif

endmodule

// ===== rtl/two_tone_wavetable_synth.sv =====
// Channel     Role   Payload                     Transaction when
// sample_in   sink   gain_level[11:0]            valid && ready
// sample_out  source duty_compare[11:0]          valid && ready
// cfg         sink   index[0], data[25:0]        valid && ready (ready is always high)
//
// One sample per cycle is sustained while the output is taken; after the edge that accepts
// its transaction a result passes the registered sine table read, the product register
// and the output register, becomes valid there, and can be taken at the next edge.
// Reset clears both phases, both steps and the stage valid bits; the table is constant.
// Each stage loads when empty or when the stage after it moves, so input stalls
// only once all three stages hold samples and the output is not taken.
module two_tone_wavetable_synth (
    input  logic       clk,
    input  logic       rst_n,
    tts_gain_if.sink   sample_in,
    tts_duty_if.source sample_out,
    tts_cfg_if.sink    cfg
);

    tts_pkg::cfg_write_t                 cfg_wr;
    logic                                load_en;
    logic                                in_fire;
    logic [tts_pkg::IDX_W-1:0]           idx0;
    logic [tts_pkg::IDX_W-1:0]           idx1;
    logic signed [tts_pkg::SAMPLE_W-1:0] sample0;
    logic signed [tts_pkg::SAMPLE_W-1:0] sample1;

    assign cfg.ready = 1'b1;
    assign cfg_wr.en = cfg.valid;
    assign cfg_wr.index = tts_pkg::cfg_reg_t'(cfg.index);
    assign cfg_wr.data = cfg.data;

    assign sample_in.ready = load_en;
    assign in_fire = sample_in.valid && load_en;

    tts_phase u_phase (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .advance (in_fire),
        .idx0    (idx0),
        .idx1    (idx1)
    );

    tts_sine_rom u_rom (
        .clk       (clk),
        .rd_en     (load_en),
        .addr0     (idx0),
        .addr1     (idx1),
        .data0_reg (sample0),
        .data1_reg (sample1)
    );

    tts_mix u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .gain_level   (sample_in.gain_level),
        .load_en      (load_en),
        .sample0      (sample0),
        .sample1      (sample1),
        .out_valid    (sample_out.valid),
        .out_ready    (sample_out.ready),
        .duty_compare (sample_out.duty_compare)
    );

endmodule
